>>> rtl/llrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llrt_pkg
// Operation codes and stream word layout of the least laxity ready table.
// ----------------------------------------------------------------------------
package llrt_pkg;

  // operation codes carried on in_tuser
  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_FRONT  = 2'd2;
  localparam op_t OP_MIN    = 2'd3;

  // fixed widths of the stream fields
  localparam int unsigned JOB_W     = 8;
  localparam int unsigned LAX_IN_W  = 32;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // input word bit positions
  localparam int unsigned IN_JOB_LSB = 0;
  localparam int unsigned IN_LAX_LSB = 8;

  // result word bit positions
  localparam int unsigned OUT_JOB_LSB   = 0;
  localparam int unsigned OUT_FOUND_BIT = 8;
  localparam int unsigned OUT_EMPTY_BIT = 9;
  localparam int unsigned OUT_OVF_BIT   = 10;

endpackage : llrt_pkg
`default_nettype wire

>>> rtl/llrt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llrt_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module llrt_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : llrt_ram
`default_nettype wire

>>> rtl/least_laxity_ready_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_laxity_ready_table_unit
// Ordered ready table of jobs with push, remove by id, front and least laxity.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)               | tuser
//  in_     | in  | job_id[7:0], laxity[39:8], pad to 40    | op[1:0]
//  out_    | out | result_job[7:0], found[8], is_empty[9], | -
//          |     | overflow[10], pad to 16                 |
//
// push: result in the cycle after accept; front: answered from a read of
// entry 0; remove and least laxity walk all n stored jobs through the single
// read port of the entry RAM, one entry a cycle (remove shifts later entries
// down through the write port on the same walk). One word is in work at a
// time. Synchronous active low reset empties the table; RAM contents need no
// clearing. A stalled result sits in the output register; a new word is
// taken once that register is free or being emptied.
// ----------------------------------------------------------------------------
module least_laxity_ready_table_unit #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_BITS  = 8,
  parameter int unsigned LAX_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // job_id[7:0], laxity[39:8]
  input  wire logic [llrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // result_job[7:0], found[8], is_empty[9], overflow[10]
  output logic      [llrt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = ID_BITS + LAX_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // control registers
  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       dat_idx_r, dat_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  // payload registers
  llrt_pkg::op_t          op_r, op_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  logic [LAX_BITS-1:0]    best_lax_r, best_lax_nxt;
  logic [ID_BITS-1:0]     best_job_r, best_job_nxt;
  logic [llrt_pkg::JOB_W-1:0] res_job_r, res_job_nxt;
  logic                   res_found_r, res_found_nxt;
  logic                   res_empty_r, res_empty_nxt;
  logic                   res_ovf_r, res_ovf_nxt;

  // RAM ports
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENT_W-1:0]       wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENT_W-1:0]       rd_data;

  // decoded input word
  logic                   in_accept;
  llrt_pkg::op_t          in_op;
  logic [ID_BITS-1:0]     in_id;
  logic [LAX_BITS-1:0]    in_lax;

  // entry read back
  logic [ID_BITS-1:0]     rd_job;
  logic [LAX_BITS-1:0]    rd_lax;
  logic                   full;
  logic [IDX_W-1:0]       last_idx;
  logic                   last;
  logic                   match;
  logic                   take;
  logic [ID_BITS-1:0]     sel_job;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign in_op     = llrt_pkg::op_t'(in_tuser);
  assign in_id     = ID_BITS'(in_tdata[llrt_pkg::IN_JOB_LSB +: llrt_pkg::JOB_W]);
  assign in_lax    = LAX_BITS'(in_tdata[llrt_pkg::IN_LAX_LSB +: llrt_pkg::LAX_IN_W]);

  assign rd_lax    = rd_data[LAX_BITS-1:0];
  assign rd_job    = rd_data[ENT_W-1:LAX_BITS];
  assign full      = (count_r == CNT_W'(DEPTH));
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign match     = (rd_job == id_r);
  assign take      = (dat_idx_r == '0) || ($signed(rd_lax) < $signed(best_lax_r));

  // entry storage, job id above laxity
  llrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dat_idx_nxt   = dat_idx_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    best_lax_nxt  = best_lax_r;
    best_job_nxt  = best_job_r;
    res_job_nxt   = res_job_r;
    res_found_nxt = res_found_r;
    res_empty_nxt = res_empty_r;
    res_ovf_nxt   = res_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {in_id, in_lax};
    rd_addr       = '0;
    last          = 1'b0;
    sel_job       = rd_job;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_accept) begin
          op_nxt      = in_op;
          id_nxt      = in_id;
          hit_nxt     = 1'b0;
          dat_idx_nxt = '0;
          if (in_op == llrt_pkg::OP_PUSH) begin
            // append at the tail or drop when full
            out_valid_nxt = 1'b1;
            res_job_nxt   = '0;
            res_found_nxt = 1'b0;
            res_empty_nxt = 1'b0;
            res_ovf_nxt   = full;
            if (!full) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            // nothing stored, answer at once
            out_valid_nxt = 1'b1;
            res_job_nxt   = '0;
            res_found_nxt = 1'b0;
            res_empty_nxt = 1'b1;
            res_ovf_nxt   = 1'b0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = dat_idx_r + IDX_W'(1);
        last    = (op_r == llrt_pkg::OP_FRONT) || (dat_idx_r == last_idx);
        case (op_r)
          llrt_pkg::OP_MIN: begin
            if (take) begin
              best_lax_nxt = rd_lax;
              best_job_nxt = rd_job;
            end
            sel_job = take ? rd_job : best_job_r;
          end
          llrt_pkg::OP_REMOVE: begin
            // after the hit, every entry moves down by one
            if (hit_r) begin
              wr_en   = 1'b1;
              wr_addr = dat_idx_r - IDX_W'(1);
              wr_data = rd_data;
            end else if (match) begin
              hit_nxt = 1'b1;
            end
          end
          default: begin
            sel_job = rd_job;
          end
        endcase
        if (last) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_ovf_nxt   = 1'b0;
          if (op_r == llrt_pkg::OP_REMOVE) begin
            res_job_nxt   = '0;
            res_found_nxt = hit_r || match;
            if (hit_r || match) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end else begin
            res_job_nxt   = llrt_pkg::JOB_W'(sel_job);
            res_found_nxt = 1'b1;
          end
          res_empty_nxt = (count_nxt == '0);
        end else begin
          dat_idx_nxt = dat_idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dat_idx_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dat_idx_r   <= dat_idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    best_lax_r  <= best_lax_nxt;
    best_job_r  <= best_job_nxt;
    res_job_r   <= res_job_nxt;
    res_found_r <= res_found_nxt;
    res_empty_r <= res_empty_nxt;
    res_ovf_r   <= res_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_ovf_r, res_empty_r, res_found_r, res_job_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == llrt_pkg::OP_PUSH && !full)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the table");

  a_scan_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN)
      |=> (count_r == $past(count_r) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("walk changed fill count by more than one");

  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result pending during walk");

endmodule : least_laxity_ready_table_unit
`default_nettype wire

>>> bench/tb_least_laxity_ready_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_laxity_ready_table_unit
// Self-checking bench for the least laxity ready table. Push, remove, front
// and least laxity words are streamed in with bursty valid and a stalling
// result side. A scoreboard class keeps its own copy of the ordered table,
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_least_laxity_ready_table_unit;

  localparam int unsigned DEPTH       = 16;
  localparam int          RANDOM_WORDS = 450;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          MAX_REPORTS  = 10;

  // one stored job of the table copy
  typedef struct {
    logic [llrt_pkg::JOB_W-1:0]           job;
    logic signed [llrt_pkg::LAX_IN_W-1:0] lax;
  } job_slot_t;

  // one predicted result word
  typedef struct {
    logic [llrt_pkg::JOB_W-1:0] job;
    logic                       found;
    logic                       empty;
    logic                       ovf;
  } ready_result_t;

  // table copy, expected results and the checks on them
  class ready_table_scoreboard;
    job_slot_t     slots[$];
    ready_result_t expected_q[$];
    int            fail_count;
    int            mismatches;
    int            results_seen;
    int            pushes_kept;
    int            pushes_dropped;
    int            remove_hits;
    int            remove_misses;
    int            empty_queries;
    int            min_queries;
    int            peak_fill;

    // work out the result of one accepted word and update the table copy
    function void note_word(llrt_pkg::op_t op, logic [llrt_pkg::JOB_W-1:0] id,
                            logic [llrt_pkg::LAX_IN_W-1:0] lax);
      ready_result_t r;
      job_slot_t     s;
      int            best;
      bit            hit;
      r = '{job: '0, found: 1'b0, empty: 1'b0, ovf: 1'b0};
      hit = 1'b0;
      best = 0;
      case (op)
        llrt_pkg::OP_PUSH: begin
          if (slots.size() >= DEPTH) begin
            r.ovf = 1'b1;
            pushes_dropped++;
          end else begin
            s.job = id;
            s.lax = lax;
            slots.push_back(s);
            pushes_kept++;
          end
        end
        llrt_pkg::OP_REMOVE: begin
          // first entry with a matching id goes, the rest keep their order
          for (int i = 0; i < slots.size(); i++) begin
            if (!hit && slots[i].job == id) begin
              hit = 1'b1;
              best = i;
            end
          end
          if (hit) begin
            slots.delete(best);
            r.found = 1'b1;
            remove_hits++;
          end else begin
            remove_misses++;
          end
        end
        llrt_pkg::OP_FRONT: begin
          if (slots.size() > 0) begin
            r.job = slots[0].job;
            r.found = 1'b1;
          end else begin
            empty_queries++;
          end
        end
        default: begin
          // least laxity, ties go to the oldest entry
          min_queries++;
          if (slots.size() > 0) begin
            for (int i = 1; i < slots.size(); i++) begin
              if ($signed(slots[i].lax) < $signed(slots[best].lax)) best = i;
            end
            r.job = slots[best].job;
            r.found = 1'b1;
          end else begin
            empty_queries++;
          end
        end
      endcase
      r.empty = (slots.size() == 0);
      if (slots.size() > peak_fill) peak_fill = slots.size();
      expected_q.push_back(r);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(logic [llrt_pkg::OUT_DATA_W-1:0] data);
      ready_result_t r;
      logic [llrt_pkg::JOB_W-1:0] got_job;
      logic got_found, got_empty, got_ovf;
      got_job   = data[llrt_pkg::OUT_JOB_LSB +: llrt_pkg::JOB_W];
      got_found = data[llrt_pkg::OUT_FOUND_BIT];
      got_empty = data[llrt_pkg::OUT_EMPTY_BIT];
      got_ovf   = data[llrt_pkg::OUT_OVF_BIT];
      results_seen++;
      if (expected_q.size() == 0) begin
        fail_count++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %0d: job %0d found %0b empty %0b ovf %0b",
                   results_seen, got_job, got_found, got_empty, got_ovf);
        return;
      end
      r = expected_q.pop_front();
      if (got_job !== r.job || got_found !== r.found || got_empty !== r.empty ||
          got_ovf !== r.ovf) begin
        fail_count++;
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch on result word %0d: expected job %0d found %0b empty %0b ovf %0b,",
                   results_seen, r.job, r.found, r.empty, r.ovf);
          $display("  got job %0d found %0b empty %0b ovf %0b",
                   got_job, got_found, got_empty, got_ovf);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // job_id[7:0], laxity[39:8]
  logic [llrt_pkg::IN_DATA_W-1:0]  in_tdata;
  // op[1:0]
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  // result_job[7:0], found[8], is_empty[9], overflow[10]
  logic [llrt_pkg::OUT_DATA_W-1:0] out_tdata;

  ready_table_scoreboard sb;
  int  words_sent;
  int  burst_left;
  bit  hold_done;

  least_laxity_ready_table_unit #(
    .DEPTH    (DEPTH),
    .ID_BITS  (8),
    .LAX_BITS (32)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog
  initial begin
    #2000000;
    $display("least_laxity_ready_table_unit verification failed");
    $finish;
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_word(llrt_pkg::op_t'(in_tuser),
                     in_tdata[llrt_pkg::IN_JOB_LSB +: llrt_pkg::JOB_W],
                     in_tdata[llrt_pkg::IN_LAX_LSB +: llrt_pkg::LAX_IN_W]);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  // offer one word, with a random gap whenever a burst runs out
  task automatic send_word(input llrt_pkg::op_t op,
                           input logic [llrt_pkg::JOB_W-1:0] id,
                           input logic [llrt_pkg::LAX_IN_W-1:0] lax);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {lax, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // result side: changing stall patterns plus one long hold-off
  initial begin
    int kind;
    int len;
    int period;
    out_tready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && words_sent >= 150) begin
        hold_done = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          @(negedge clk);
          out_tready = 1'b0;
        end
      end
      kind   = $urandom_range(0, 3);
      len    = $urandom_range(10, 60);
      period = $urandom_range(2, 6);
      for (int c = 0; c < len; c++) begin
        @(negedge clk);
        case (kind)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 1) == 1);
          2:       out_tready = ($urandom_range(0, 4) != 0);
          default: out_tready = (c % period == 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    int            mode;
    int            seg_left;
    int            pick;
    llrt_pkg::op_t op;
    logic [7:0]    id;
    logic [31:0]   lax;
    sb = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = llrt_pkg::OP_PUSH;
    words_sent = 0;
    burst_left = $urandom_range(1, 40);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // queries and remove on an empty table
    send_word(llrt_pkg::OP_FRONT, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_MIN, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_REMOVE, 8'd5, 32'd0);
    // fill up with extreme ids and laxities, including a tie and a duplicate id
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       send_word(llrt_pkg::OP_PUSH, 8'd0, 32'h7fff_ffff);
        1:       send_word(llrt_pkg::OP_PUSH, 8'd255, 32'h8000_0000);
        2:       send_word(llrt_pkg::OP_PUSH, 8'd17, 32'h8000_0000);
        3:       send_word(llrt_pkg::OP_PUSH, 8'd17, 32'h0000_0000);
        default: send_word(llrt_pkg::OP_PUSH, 8'(i * 13 + 1), $urandom());
      endcase
    end
    // push into a full table is dropped
    send_word(llrt_pkg::OP_PUSH, 8'd200, 32'hffff_ffff);
    send_word(llrt_pkg::OP_MIN, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_FRONT, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_REMOVE, 8'd200, 32'd0);
    send_word(llrt_pkg::OP_REMOVE, 8'd255, 32'd0);
    send_word(llrt_pkg::OP_MIN, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_REMOVE, 8'd17, 32'd0);
    send_word(llrt_pkg::OP_REMOVE, 8'd0, 32'd0);
    send_word(llrt_pkg::OP_FRONT, 8'd0, 32'd0);

    // random segments: filling, draining, mixed and noise
    seg_left = 0;
    mode = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 40);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      case (mode)
        0:       op = (pick < 75) ? llrt_pkg::OP_PUSH :
                      ((pick < 85) ? llrt_pkg::OP_REMOVE :
                      ((pick < 92) ? llrt_pkg::OP_FRONT : llrt_pkg::OP_MIN));
        1:       op = (pick < 65) ? llrt_pkg::OP_REMOVE :
                      ((pick < 75) ? llrt_pkg::OP_PUSH :
                      ((pick < 87) ? llrt_pkg::OP_FRONT : llrt_pkg::OP_MIN));
        2:       op = (pick < 35) ? llrt_pkg::OP_PUSH :
                      ((pick < 60) ? llrt_pkg::OP_REMOVE :
                      ((pick < 75) ? llrt_pkg::OP_FRONT : llrt_pkg::OP_MIN));
        default: op = llrt_pkg::op_t'($urandom_range(0, 3));
      endcase
      // ids: mostly fresh, some from a small set to force duplicates
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) :
                                         8'($urandom_range(0, 255));
      if (op == llrt_pkg::OP_REMOVE && mode != 3 && sb.slots.size() > 0 &&
          $urandom_range(0, 99) < 85)
        id = sb.slots[$urandom_range(0, sb.slots.size() - 1)].job;
      // laxities: full range, extremes, or a few values that tie
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 3))
            0:       lax = 32'h8000_0000;
            1:       lax = 32'h7fff_ffff;
            2:       lax = 32'h0000_0000;
            default: lax = 32'hffff_ffff;
          endcase
        end
        1:       lax = 32'($signed($urandom_range(0, 4)) - 2) << 16;
        default: lax = $urandom();
      endcase
      send_word(op, id, lax);
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    // let every expected result arrive, then watch for stray words
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.fail_count++;

    $display("%0d words in, %0d results checked, %0d mismatches; peak fill %0d of %0d",
             words_sent, sb.results_seen, sb.mismatches, sb.peak_fill, DEPTH);
    $display("pushes kept %0d dropped %0d, removes hit %0d missed %0d,",
             sb.pushes_kept, sb.pushes_dropped, sb.remove_hits, sb.remove_misses);
    $display("least laxity %0d, empty queries %0d", sb.min_queries, sb.empty_queries);
    if (sb.fail_count == 0) begin
      $display("least_laxity_ready_table_unit verification clean");
    end else begin
      $display("least_laxity_ready_table_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/llrt_pkg.sv
rtl/llrt_ram.sv
rtl/least_laxity_ready_table_unit.sv
bench/tb_least_laxity_ready_table_unit.sv
